@@ sv/gsac_pkg.sv @@
// ----------------------------------------------------------------------------
// gsac_pkg
// Shared types and constants for the gamepad stick and auto-repeat
// conditioner: register indexes, reset values, field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gsac_pkg;

  // field widths
  localparam int unsigned PadW   = 16;
  localparam int unsigned BtnW   = 20;
  localparam int unsigned AxisW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 8;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_DEADZONE        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_THRESHOLD = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_MARGIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_DELAY    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_INTERVAL = 3'd4;

  // register reset values
  localparam logic [4:0] RST_DEADZONE        = 5'd4;
  localparam logic [6:0] RST_PRESS_THRESHOLD = 7'd32;
  localparam logic [6:0] RST_RELEASE_MARGIN  = 7'd16;
  localparam logic [7:0] RST_REPEAT_DELAY    = 8'd15;
  localparam logic [7:0] RST_REPEAT_INTERVAL = 8'd4;

  // positions of the stick direction bits in the button word
  localparam int unsigned BIT_RIGHT = 16;
  localparam int unsigned BIT_LEFT  = 17;
  localparam int unsigned BIT_DOWN  = 18;
  localparam int unsigned BIT_UP    = 19;

  // configuration register set
  typedef struct packed {
    logic [4:0] deadzone;
    logic [6:0] press_threshold;
    logic [6:0] release_margin;
    logic [7:0] repeat_delay;
    logic [7:0] repeat_interval;
  } cfg_t;

endpackage : gsac_pkg

`default_nettype wire

@@ sv/gsac_axis.sv @@
// ----------------------------------------------------------------------------
// gsac_axis
// One stick axis: deadzone removal, press threshold and the extreme tracker
// with outward/inward hysteresis that lets a direction retrigger.
// ----------------------------------------------------------------------------
`default_nettype none

module gsac_axis (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd,
  input  logic signed [7:0]   raw,
  input  gsac_pkg::cfg_t      cfg,
  input  logic                prev_pos,
  input  logic                prev_neg,
  output logic signed [7:0]   s_out,
  output logic                pos_bit,
  output logic                neg_bit
);
  import gsac_pkg::*;

  logic signed [7:0] ext_r, ext_nxt;
  logic              inw_r, inw_nxt;

  logic signed [8:0] raw_e, dz_e, s_dz, s_e, thr_e;
  logic signed [7:0] s;
  logic              hit_pos, hit_neg;
  logic              inw1;
  logic signed [9:0] s_w, x_w, m_w, d_up, d_dn;

  // deadzone toward zero, clamped at zero
  always_comb begin
    raw_e = {raw[7], raw};
    dz_e  = {4'b0, cfg.deadzone};
    s_dz  = 9'sd0;
    if (raw_e > 9'sd0) begin
      s_dz = raw_e - dz_e;
      if (s_dz < 9'sd0) s_dz = 9'sd0;
    end else if (raw_e < 9'sd0) begin
      s_dz = raw_e + dz_e;
      if (s_dz > 9'sd0) s_dz = 9'sd0;
    end
    s = s_dz[7:0];
  end

  // threshold and extreme tracking
  always_comb begin
    s_e     = {s[7], s};
    thr_e   = {2'b0, cfg.press_threshold};
    hit_pos = (s_e > thr_e);
    hit_neg = (s_e < -thr_e);
    ext_nxt = ext_r;
    inw1    = inw_r;
    if (hit_pos) begin
      if (!prev_pos)      ext_nxt = s;
      else if (!inw_r)    ext_nxt = (ext_r < s) ? s : ext_r;
      else                ext_nxt = (ext_r > s) ? s : ext_r;
    end else if (hit_neg) begin
      if (!prev_neg)      ext_nxt = s;
      else if (!inw_r)    ext_nxt = (ext_r > s) ? s : ext_r;
      else                ext_nxt = (ext_r < s) ? s : ext_r;
    end else begin
      ext_nxt = s;
      inw1    = 1'b0;
    end
  end

  // hysteresis: reversal past the margin flips direction state
  always_comb begin
    s_w     = {{2{s[7]}}, s};
    x_w     = {{2{ext_nxt[7]}}, ext_nxt};
    m_w     = {3'b0, cfg.release_margin};
    d_up    = s_w - x_w;
    d_dn    = x_w - s_w;
    pos_bit = hit_pos;
    neg_bit = hit_neg;
    inw_nxt = inw1;
    if (hit_pos) begin
      if (inw1 && (d_up > m_w)) begin
        pos_bit = 1'b0;
        inw_nxt = 1'b0;
      end
      if (d_dn > m_w) inw_nxt = 1'b1;
    end
    if (hit_neg) begin
      if (inw1 && (d_dn > m_w)) begin
        neg_bit = 1'b0;
        inw_nxt = 1'b0;
      end
      if (d_up > m_w) inw_nxt = 1'b1;
    end
  end

  assign s_out = s;

  // axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= '0;
      inw_r <= 1'b0;
    end else if (upd) begin
      ext_r <= ext_nxt;
      inw_r <= inw_nxt;
    end
  end

endmodule : gsac_axis

`default_nettype wire

@@ sv/gsac_repeat.sv @@
// ----------------------------------------------------------------------------
// gsac_repeat
// Edge detect and auto-repeat timing over the 20-bit button word: initial
// delay countdown, then a pulse every repeat interval while held.
// ----------------------------------------------------------------------------
`default_nettype none

module gsac_repeat (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic [gsac_pkg::BtnW-1:0]     cur,
  input  gsac_pkg::cfg_t                cfg,
  output logic [gsac_pkg::BtnW-1:0]     prev,
  output logic [gsac_pkg::BtnW-1:0]     fresh,
  output logic [gsac_pkg::BtnW-1:0]     pulses
);
  import gsac_pkg::*;

  logic [BtnW-1:0]   prev_r;
  logic signed [8:0] rpt_r, rpt_nxt, rpt_dec;
  logic [7:0]        dly_r, dly_nxt, dly_dec;

  assign prev  = prev_r;
  assign fresh = cur & ~prev_r;

  // counter update and pulse selection
  always_comb begin
    rpt_nxt = rpt_r;
    dly_nxt = dly_r;
    rpt_dec = rpt_r - 9'sd1;
    dly_dec = dly_r - 8'd1;
    pulses  = '0;
    if (cur == '0) begin
      pulses = '0;
    end else if (cur != prev_r) begin
      pulses  = fresh;
      dly_nxt = cfg.repeat_delay;
      rpt_nxt = -9'sd1;
    end else if (!rpt_r[8]) begin
      if (rpt_dec != 9'sd0) begin
        rpt_nxt = rpt_dec;
      end else begin
        pulses  = cur;
        rpt_nxt = {1'b0, cfg.repeat_interval};
      end
    end else begin
      dly_nxt = dly_dec;
      if (dly_dec == 8'd0) begin
        pulses  = cur;
        rpt_nxt = {1'b0, cfg.repeat_interval};
      end
    end
  end

  // repeat state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      rpt_r  <= '0;
      dly_r  <= '0;
    end else if (upd) begin
      prev_r <= cur;
      rpt_r  <= rpt_nxt;
      dly_r  <= dly_nxt;
    end
  end

endmodule : gsac_repeat

`default_nettype wire

@@ sv/gamepad_stick_and_autorepeat_conditioner_core.sv @@
// ----------------------------------------------------------------------------
// gamepad_stick_and_autorepeat_conditioner_core
// Conditions one controller frame per request: stick deadzone, direction
// bits with retrigger hysteresis, edge detect and button auto-repeat.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+------------------------------
//  input   | in_pad_buttons, in_raw_stick_* | in_valid / in_ready
//  result  | out_current_buttons ... y_out  | out_valid / out_ready
//  config  | cfg_index, cfg_data            | cfg_wr_en, no wait
//
//  One frame per cycle sustained while the result side is not stalled; an
//  accepted frame moves through the input register, then the result register.
//  All conditioning runs in one pass between the two registers; state is
//  updated when a frame moves into the result register.
//  A stalled result holds in the result register while the input register
//  still takes one more frame. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_stick_and_autorepeat_conditioner_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input frame channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gsac_pkg::PadW-1:0]         in_pad_buttons,
  input  logic signed [gsac_pkg::AxisW-1:0] in_raw_stick_x,
  input  logic signed [gsac_pkg::AxisW-1:0] in_raw_stick_y,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gsac_pkg::BtnW-1:0]         out_current_buttons,
  output logic [gsac_pkg::BtnW-1:0]         out_new_presses,
  output logic [gsac_pkg::BtnW-1:0]         out_repeat_pulses,
  output logic signed [gsac_pkg::AxisW-1:0] out_stick_x_out,
  output logic signed [gsac_pkg::AxisW-1:0] out_stick_y_out,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [gsac_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [gsac_pkg::CfgDatW-1:0]      cfg_data
);
  import gsac_pkg::*;

  cfg_t                     cfg_r;
  logic                     in_vld_r;
  logic [PadW-1:0]          pad_r;
  logic signed [AxisW-1:0]  x_r, y_r;
  logic                     out_vld_r;
  logic [BtnW-1:0]          cur_btn_r, new_r, rpt_r;
  logic signed [AxisW-1:0]  sx_out_r, sy_out_r;

  logic                     adv;
  logic [BtnW-1:0]          prev, fresh, pulses, cur;
  logic signed [AxisW-1:0]  sx, sy;
  logic                     right_bit, left_bit, up_bit, down_bit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone        <= RST_DEADZONE;
      cfg_r.press_threshold <= RST_PRESS_THRESHOLD;
      cfg_r.release_margin  <= RST_RELEASE_MARGIN;
      cfg_r.repeat_delay    <= RST_REPEAT_DELAY;
      cfg_r.repeat_interval <= RST_REPEAT_INTERVAL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEADZONE:        cfg_r.deadzone        <= cfg_data[4:0];
        CFG_PRESS_THRESHOLD: cfg_r.press_threshold <= cfg_data[6:0];
        CFG_RELEASE_MARGIN:  cfg_r.release_margin  <= cfg_data[6:0];
        CFG_REPEAT_DELAY:    cfg_r.repeat_delay    <= cfg_data;
        CFG_REPEAT_INTERVAL: cfg_r.repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pad_r <= in_pad_buttons;
      x_r   <= in_raw_stick_x;
      y_r   <= in_raw_stick_y;
    end
  end

  // horizontal axis: right positive, left negative
  gsac_axis u_axis_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (adv),
    .raw      (x_r),
    .cfg      (cfg_r),
    .prev_pos (prev[BIT_RIGHT]),
    .prev_neg (prev[BIT_LEFT]),
    .s_out    (sx),
    .pos_bit  (right_bit),
    .neg_bit  (left_bit)
  );

  // vertical axis: up positive, down negative
  gsac_axis u_axis_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (adv),
    .raw      (y_r),
    .cfg      (cfg_r),
    .prev_pos (prev[BIT_UP]),
    .prev_neg (prev[BIT_DOWN]),
    .s_out    (sy),
    .pos_bit  (up_bit),
    .neg_bit  (down_bit)
  );

  assign cur = {up_bit, down_bit, left_bit, right_bit, pad_r};

  // edge detect and auto-repeat
  gsac_repeat u_repeat (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (adv),
    .cur    (cur),
    .cfg    (cfg_r),
    .prev   (prev),
    .fresh  (fresh),
    .pulses (pulses)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cur_btn_r <= cur;
      new_r     <= fresh;
      rpt_r     <= pulses;
      sx_out_r  <= sx;
      sy_out_r  <= sy;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_current_buttons = cur_btn_r;
  assign out_new_presses     = new_r;
  assign out_repeat_pulses   = rpt_r;
  assign out_stick_x_out     = sx_out_r;
  assign out_stick_y_out     = sy_out_r;

endmodule : gamepad_stick_and_autorepeat_conditioner_core

`default_nettype wire

@@ sv/gsac_checker.sv @@
// ----------------------------------------------------------------------------
// gsac_checker
// Port-level checks on the conditioner's result channel, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gsac_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              out_valid,
  input  wire                              out_ready,
  input  wire [gsac_pkg::BtnW-1:0]         out_current_buttons,
  input  wire [gsac_pkg::BtnW-1:0]         out_new_presses,
  input  wire [gsac_pkg::BtnW-1:0]         out_repeat_pulses,
  input  wire signed [gsac_pkg::AxisW-1:0] out_stick_x_out,
  input  wire signed [gsac_pkg::AxisW-1:0] out_stick_y_out
);
  import gsac_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_current_buttons)
      && $stable(out_new_presses) && $stable(out_repeat_pulses)
      && $stable(out_stick_x_out) && $stable(out_stick_y_out))
    else $error("result changed while stalled");

  // new presses are always a subset of the current bits
  a_new_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_new_presses & ~out_current_buttons) == '0)
    else $error("new press on a released bit");

  // no repeat pulse with nothing held
  a_rpt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_current_buttons == '0) |-> out_repeat_pulses == '0)
    else $error("repeat pulse with no bit set");

  // opposite directions exclusive, and right and up match the axis sign
  a_dir_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_current_buttons[BIT_RIGHT] && out_current_buttons[BIT_LEFT])
      && !(out_current_buttons[BIT_UP] && out_current_buttons[BIT_DOWN])
      && (!out_current_buttons[BIT_RIGHT] || (out_stick_x_out > 0))
      && (!out_current_buttons[BIT_UP] || (out_stick_y_out > 0)))
    else $error("stick direction bits inconsistent");

endmodule : gsac_checker

bind gamepad_stick_and_autorepeat_conditioner_core gsac_checker u_gsac_checker (.*);

`default_nettype wire
